// File: hdl/pps_pkg.sv
// Shared types and constants for the preemptive priority scheduler.
package pps_pkg;

  localparam int PC_W       = 5;
  localparam int SLOT_W     = 4;
  localparam int BURST_W    = 8;
  localparam int ARR_W      = 16;
  localparam int PRIO_W     = 8;
  localparam int TICK_W     = 20;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 48;

  localparam logic [PC_W-1:0]   PC_RESET = 5'd16;
  localparam logic [TICK_W-1:0] TICK_MAX = 20'hFFFFF;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LOAD = 5'b00010,
    S_SCAN = 5'b00100,
    S_UPD  = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  // Input word, lowest field in the lowest bits.
  typedef struct packed {
    logic [3:0]         pad;
    logic [PRIO_W-1:0]  priority_level;
    logic [ARR_W-1:0]   arrival_time;
    logic [BURST_W-1:0] burst_time;
    logic [SLOT_W-1:0]  slot;
  } pps_in_t;

  // Result word, lowest field in the lowest bits.
  typedef struct packed {
    logic [1:0]        pad;
    logic              all_done;
    logic [TICK_W-1:0] waiting;
    logic [TICK_W-1:0] turnaround;
    logic              finished;
    logic [SLOT_W-1:0] running_slot;
  } pps_out_t;

  // One task slot as stored in the table.
  typedef struct packed {
    logic [BURST_W-1:0] remaining;
    logic [BURST_W-1:0] burst;
    logic [ARR_W-1:0]   ready;
    logic [PRIO_W-1:0]  urg;
  } pps_entry_t;

  // Verdict of the compare unit on one slot.
  typedef struct packed {
    logic take;
    logic nonzero;
  } pps_cmp_t;

endpackage

// File: hdl/preemptive_priority_scheduler.sv
// Preemptive priority scheduler: task table in RAM, scanned by one compare unit.
// Words are handled one at a time: in_tready is high only in S_IDLE, so no new word is taken
// until the last result has entered the output register; the scan covers n = slots in use (1..MAX_TASKS).
// The scan reads one table slot per cycle through the single RAM read port;
// a stalled result holds the next word at its end.
// Reset (rst_n low, synchronous): slot table reads as empty, time is zero, slot count is 16.
module preemptive_priority_scheduler #(
  parameter int MAX_TASKS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // slot[3:0], burst_time[11:4], arrival_time[27:12], priority_level[35:28], zero pad
  input  logic [pps_pkg::IN_DATA_W-1:0]  in_tdata,
  // opcode
  input  logic                           in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // running_slot[3:0], finished[4], turnaround[24:5], waiting[44:25], all_done[45], zero pad
  output logic [pps_pkg::OUT_DATA_W-1:0] out_tdata,
  // idle
  output logic                           out_tuser,
  input  logic                           cfg_we,
  input  logic [pps_pkg::PC_W-1:0]       cfg_wdata
);
  import pps_pkg::*;

  localparam int IDX_W = $clog2(MAX_TASKS);
  localparam int CNT_W = $clog2(MAX_TASKS + 1);
  localparam int CMP_W = (CNT_W > PC_W) ? CNT_W : PC_W;
  localparam int ENT_W = $bits(pps_entry_t);

  state_t              state_r, state_nxt;
  logic [PC_W-1:0]     pc_r, pc_nxt;
  pps_in_t             in_r, in_nxt;
  op_t                 op_r, op_nxt;
  logic [TICK_W-1:0]   tick_r, tick_nxt;
  logic [MAX_TASKS-1:0] valid_r, valid_nxt;
  logic                valid_q_r;
  logic [CNT_W-1:0]    rd_cnt_r, rd_cnt_nxt;
  logic                cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]    cmp_idx_r, cmp_idx_nxt;
  logic                found_r, found_nxt;
  logic [IDX_W-1:0]    best_idx_r, best_idx_nxt;
  pps_entry_t          best_ent_r, best_ent_nxt;
  logic [CNT_W-1:0]    nz_r, nz_nxt;
  logic                fin_r, fin_nxt;
  logic [TICK_W-1:0]   ta_r, ta_nxt;
  pps_out_t            res_r, res_nxt;
  logic                res_idle_r, res_idle_nxt;
  logic                out_vld_r, out_vld_nxt;
  pps_out_t            out_data_r, out_data_nxt;
  logic                out_idle_r, out_idle_nxt;

  logic [CMP_W-1:0]    n_ext;
  logic [CNT_W-1:0]    n_cnt;
  logic [CMP_W-1:0]    slot_ext;
  logic                slot_ok;
  logic [IDX_W-1:0]    ld_addr;
  logic [CMP_W-1:0]    best_ext;
  logic [TICK_W-1:0]   done_at;

  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  pps_entry_t          ram_wdata;
  logic [IDX_W-1:0]    ram_raddr;
  logic [ENT_W-1:0]    ram_rdata;
  pps_entry_t          ent_rd;
  pps_cmp_t            cmp_res;

  // clamp the slot count into 1..MAX_TASKS
  always_comb begin
    n_ext = CMP_W'(pc_r);
    if (n_ext == '0) begin
      n_ext = CMP_W'(1);
    end else if (n_ext > CMP_W'(MAX_TASKS)) begin
      n_ext = CMP_W'(MAX_TASKS);
    end
    n_cnt = n_ext[CNT_W-1:0];
  end

  assign slot_ext  = CMP_W'(in_r.slot);
  assign slot_ok   = slot_ext < CMP_W'(MAX_TASKS);
  assign ld_addr   = slot_ext[IDX_W-1:0];
  assign best_ext  = CMP_W'(best_idx_r);
  assign ram_raddr = rd_cnt_r[IDX_W-1:0];
  assign ent_rd    = pps_entry_t'(ram_rdata);
  assign done_at   = (tick_r < TICK_MAX) ? tick_r + TICK_W'(1) : tick_r;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = best_idx_r;
    ram_wdata = best_ent_r;
    ram_wdata.remaining = best_ent_r.remaining - BURST_W'(1);
    if (state_r == S_LOAD) begin
      ram_we              = slot_ok;
      ram_waddr           = ld_addr;
      ram_wdata.remaining = in_r.burst_time;
      ram_wdata.burst     = in_r.burst_time;
      ram_wdata.ready     = in_r.arrival_time;
      ram_wdata.urg       = in_r.priority_level;
    end else if (state_r == S_UPD) begin
      ram_we = (op_r == OP_TICK) && found_r;
    end
  end

  pps_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_TASKS)
  ) u_pps_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pps_cmp u_pps_cmp (
    .ent      (ent_rd),
    .ent_ok   (valid_q_r),
    .tick     (tick_r),
    .found    (found_r),
    .best_urg (best_ent_r.urg),
    .res      (cmp_res)
  );

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    pc_nxt       = pc_r;
    in_nxt       = in_r;
    op_nxt       = op_r;
    tick_nxt     = tick_r;
    valid_nxt    = valid_r;
    rd_cnt_nxt   = rd_cnt_r;
    cmp_vld_nxt  = cmp_vld_r;
    cmp_idx_nxt  = cmp_idx_r;
    found_nxt    = found_r;
    best_idx_nxt = best_idx_r;
    best_ent_nxt = best_ent_r;
    nz_nxt       = nz_r;
    fin_nxt      = fin_r;
    ta_nxt       = ta_r;
    res_nxt      = res_r;
    res_idle_nxt = res_idle_r;
    out_vld_nxt  = out_vld_r;
    out_data_nxt = out_data_r;
    out_idle_nxt = out_idle_r;

    if (cfg_we) begin
      pc_nxt = cfg_wdata;
    end
    if (out_vld_r && out_tready) begin
      out_vld_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          in_nxt      = pps_in_t'(in_tdata);
          op_nxt      = op_t'(in_tuser);
          rd_cnt_nxt  = '0;
          cmp_vld_nxt = 1'b0;
          found_nxt   = 1'b0;
          nz_nxt      = '0;
          state_nxt   = (op_t'(in_tuser) == OP_LOAD) ? S_LOAD : S_SCAN;
        end
      end
      S_LOAD: begin
        tick_nxt = '0;
        if (slot_ok) begin
          valid_nxt[ld_addr] = 1'b1;
        end
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        // issue one read per cycle, compare its data in the next cycle
        if (rd_cnt_r != n_cnt) begin
          rd_cnt_nxt  = rd_cnt_r + CNT_W'(1);
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = ram_raddr;
        end else begin
          cmp_vld_nxt = 1'b0;
          state_nxt   = S_UPD;
        end
        if (cmp_vld_r) begin
          if (cmp_res.take) begin
            found_nxt    = 1'b1;
            best_idx_nxt = cmp_idx_r;
            best_ent_nxt = ent_rd;
          end
          if (cmp_res.nonzero) begin
            nz_nxt = nz_r + CNT_W'(1);
          end
        end
      end
      S_UPD: begin
        fin_nxt = (op_r == OP_TICK) && found_r && (best_ent_r.remaining == BURST_W'(1));
        ta_nxt  = done_at - TICK_W'(best_ent_r.ready);
        if (op_r == OP_TICK) begin
          tick_nxt = done_at;
        end
        res_nxt.pad          = '0;
        res_nxt.running_slot = ((op_r == OP_TICK) && found_r) ? best_ext[SLOT_W-1:0] : '0;
        res_idle_nxt         = !((op_r == OP_TICK) && found_r);
        res_nxt.finished     = fin_nxt;
        res_nxt.all_done     = fin_nxt ? (nz_r == CNT_W'(1)) : (nz_r == '0);
        state_nxt            = S_FIN;
      end
      S_FIN: begin
        res_nxt.turnaround = fin_r ? ta_r : '0;
        res_nxt.waiting    = (fin_r && (ta_r >= TICK_W'(best_ent_r.burst))) ?
                             ta_r - TICK_W'(best_ent_r.burst) : '0;
        // hold until the output register is free
        if (!out_vld_r || out_tready) begin
          out_vld_nxt  = 1'b1;
          out_data_nxt = res_nxt;
          out_idle_nxt = res_idle_r;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      pc_r      <= PC_RESET;
      tick_r    <= '0;
      valid_r   <= '0;
      cmp_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
      found_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      pc_r      <= pc_nxt;
      tick_r    <= tick_nxt;
      valid_r   <= valid_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      out_vld_r <= out_vld_nxt;
      found_r   <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_r       <= in_nxt;
    op_r       <= op_nxt;
    valid_q_r  <= valid_r[ram_raddr];
    rd_cnt_r   <= rd_cnt_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    best_idx_r <= best_idx_nxt;
    best_ent_r <= best_ent_nxt;
    nz_r       <= nz_nxt;
    fin_r      <= fin_nxt;
    ta_r       <= ta_nxt;
    res_r      <= res_nxt;
    res_idle_r <= res_idle_nxt;
    out_data_r <= out_data_nxt;
    out_idle_r <= out_idle_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_idle_r;

endmodule

// File: hdl/pps_ram.sv
// Generic simple dual-port RAM with registered read.
module pps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/pps_cmp.sv
// Shared compare unit: judges one slot against the best candidate so far.
module pps_cmp (
  input  pps_pkg::pps_entry_t         ent,
  input  logic                        ent_ok,
  input  logic [pps_pkg::TICK_W-1:0]  tick,
  input  logic                        found,
  input  logic [pps_pkg::PRIO_W-1:0]  best_urg,
  output pps_pkg::pps_cmp_t           res
);
  import pps_pkg::*;

  pps_entry_t e;
  logic       eligible;

  always_comb begin
    // a slot never loaded reads as all zero
    e           = ent_ok ? ent : '0;
    eligible    = (TICK_W'(e.ready) <= tick) && (e.remaining != '0);
    res.take    = eligible && (!found || (e.urg < best_urg));
    res.nonzero = (e.remaining != '0);
  end

endmodule

// File: hdl/pps_checker.sv
// Port-level checks for the preemptive priority scheduler, bound to the top level.
module pps_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [pps_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                           out_tuser
);
  import pps_pkg::*;

  pps_out_t ow;

  assign ow = pps_out_t'(out_tdata);

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result word changed");

  // one word at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while a word is in progress");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> (ow.running_slot == '0) && !ow.finished)
    else $error("idle result carries a running slot or completion");

  a_no_fin_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !ow.finished |-> (ow.turnaround == '0) && (ow.waiting == '0))
    else $error("times reported without a completion");

  a_wait_le_tat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && ow.finished |-> ow.waiting <= ow.turnaround)
    else $error("waiting time exceeds turnaround");

endmodule

bind preemptive_priority_scheduler pps_checker u_pps_checker (.*);

// File: tb/preemptive_priority_scheduler_tb.sv
// Self-checking testbench for the preemptive priority scheduler: directed table, then random runs.
module preemptive_priority_scheduler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pps_pkg::*;

  localparam int MAX_SLOTS    = 16;
  localparam int STALL_LIMIT  = 3000;
  localparam int SETTLE_TICKS = 2 * MAX_SLOTS + 10;
  localparam int RANDOM_WORDS = 1600;
  localparam int CALM_WORDS   = 200;
  localparam int TICK_CAP     = 60;

  typedef struct packed {
    logic [SLOT_W-1:0] running_slot;
    logic              idle;
    logic              finished;
    logic [TICK_W-1:0] turnaround;
    logic [TICK_W-1:0] waiting;
    logic              all_done;
  } sched_res_t;

  typedef enum logic {
    ROW_ITEM = 1'b0,
    ROW_CFG  = 1'b1
  } row_kind_t;

  typedef struct {
    row_kind_t kind;
    op_t       op;
    int        slot;
    int        burst;
    int        arrival;
    int        prio;
    int        cfg_val;
    bit        typed;
    bit        exp_done;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  cfg_we = 1'b0;
  logic [PC_W-1:0]       cfg_wdata = '0;

  // Scheduler shadow state
  logic [BURST_W-1:0] task_left   [MAX_SLOTS];
  logic [BURST_W-1:0] task_burst  [MAX_SLOTS];
  logic [ARR_W-1:0]   task_arrive [MAX_SLOTS];
  logic [PRIO_W-1:0]  task_urg    [MAX_SLOTS];
  logic [TICK_W-1:0]  sched_tick = '0;
  int                 done_count = 0;
  logic [PC_W-1:0]    slot_cfg = PC_RESET;

  sched_res_t expected_q[$];
  dir_row_t   dir_rows[$];
  int         error_count = 0;
  int         words_sent = 0;
  int         quiet_cycles = 0;
  int         stall_left = 0;
  bit         calm = 1'b0;

  preemptive_priority_scheduler #(.MAX_TASKS(MAX_SLOTS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  initial begin
    for (int i = 0; i < MAX_SLOTS; i++) begin
      task_left[i]   = '0;
      task_burst[i]  = '0;
      task_arrive[i] = '0;
      task_urg[i]    = '0;
    end
  end

  function automatic int active_slots();
    int n;
    n = slot_cfg;
    if (n == 0) n = 1;
    if (n > MAX_SLOTS) n = MAX_SLOTS;
    return n;
  endfunction

  function automatic bit table_done();
    bit done;
    done = 1'b1;
    for (int i = 0; i < active_slots(); i++)
      if (task_left[i] != '0) done = 1'b0;
    return done;
  endfunction

  function automatic sched_res_t schedule_word(op_t op, logic [SLOT_W-1:0] s,
                                               logic [BURST_W-1:0] b, logic [ARR_W-1:0] a,
                                               logic [PRIO_W-1:0] p);
    sched_res_t        r;
    int                n;
    bit                found;
    int                best;
    logic [TICK_W-1:0] done_at;
    logic [TICK_W-1:0] ta;
    r = '0;
    r.idle = 1'b1;
    if (op == OP_LOAD) begin
      task_burst[s]  = b;
      task_left[s]   = b;
      task_arrive[s] = a;
      task_urg[s]    = p;
      sched_tick     = '0;
      done_count     = 0;
    end else begin
      n = active_slots();
      found = 1'b0;
      best = 0;
      // Strict compare keeps the lowest slot on a priority tie
      for (int i = 0; i < n; i++) begin
        if (TICK_W'(task_arrive[i]) <= sched_tick && task_left[i] != '0 &&
            (!found || task_urg[i] < task_urg[best])) begin
          best = i;
          found = 1'b1;
        end
      end
      if (found) begin
        r.idle = 1'b0;
        r.running_slot = SLOT_W'(best);
        task_left[best] = task_left[best] - 1'b1;
        if (task_left[best] == '0) begin
          done_at = (sched_tick != TICK_MAX) ? sched_tick + 1'b1 : TICK_MAX;
          ta = done_at - TICK_W'(task_arrive[best]);
          r.finished = 1'b1;
          r.turnaround = ta;
          r.waiting = (ta >= TICK_W'(task_burst[best])) ? ta - TICK_W'(task_burst[best]) : '0;
          if (done_count < 31) done_count++;
        end
      end
      if (sched_tick != TICK_MAX) sched_tick = sched_tick + 1'b1;
    end
    r.all_done = table_done();
    return r;
  endfunction

  function automatic logic [BURST_W-1:0] rand_burst();
    case ($urandom_range(0, 9))
      0: return BURST_W'($urandom_range(0, 255));
      1: return '0;
      default: return BURST_W'($urandom_range(1, 6));
    endcase
  endfunction

  function automatic logic [ARR_W-1:0] rand_arrival();
    if ($urandom_range(0, 9) == 0) return ARR_W'($urandom_range(0, 65535));
    return ARR_W'($urandom_range(0, 12));
  endfunction

  function automatic logic [PRIO_W-1:0] rand_prio();
    // Narrow range half the time to force ties
    if ($urandom_range(0, 1) == 0) return PRIO_W'($urandom_range(0, 3));
    return PRIO_W'($urandom_range(0, 255));
  endfunction

  function automatic void add_row(row_kind_t k, op_t op, int s, int b, int a, int p,
                                  int cv, bit typed, bit done);
    dir_row_t row;
    row.kind = k;
    row.op = op;
    row.slot = s;
    row.burst = b;
    row.arrival = a;
    row.prio = p;
    row.cfg_val = cv;
    row.typed = typed;
    row.exp_done = done;
    dir_rows.push_back(row);
  endfunction

  task automatic send_word(op_t op, logic [SLOT_W-1:0] s, logic [BURST_W-1:0] b,
                           logic [ARR_W-1:0] a, logic [PRIO_W-1:0] p,
                           bit typed, sched_res_t typed_res);
    pps_in_t    w;
    sched_res_t r;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    w.pad = '0;
    w.slot = s;
    w.burst_time = b;
    w.arrival_time = a;
    w.priority_level = p;
    in_tvalid <= 1'b1;
    in_tdata <= w;
    in_tuser <= op;
    do @(posedge clk); while (!in_tready);
    r = schedule_word(op, s, b, a, p);
    expected_q.push_back(typed ? typed_res : r);
    words_sent++;
  endtask

  task automatic send_tick();
    send_word(OP_TICK, SLOT_W'($urandom_range(0, 15)), rand_burst(), rand_arrival(),
              rand_prio(), 1'b0, '0);
  endtask

  task automatic send_load(int s);
    send_word(OP_LOAD, SLOT_W'(s), rand_burst(), rand_arrival(), rand_prio(), 1'b0, '0);
  endtask

  // Drain all results and let the block settle before touching the register
  task automatic set_slot_count(logic [PC_W-1:0] v);
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    slot_cfg = v;
  endtask

  task automatic check_field(string name, logic [TICK_W-1:0] want, logic [TICK_W-1:0] got);
    if (want !== got) begin
      error_count++;
      if (error_count <= 10)
        $display("mismatch in %s: expected %0d, got %0d", name, want, got);
    end
  endtask

  task automatic check_result();
    pps_out_t   got;
    sched_res_t want;
    got = out_tdata;
    if (expected_q.size() == 0) begin
      error_count++;
      if (error_count <= 10) $display("result word with nothing expected: %h", out_tdata);
    end else begin
      want = expected_q.pop_front();
      check_field("running_slot", TICK_W'(want.running_slot), TICK_W'(got.running_slot));
      check_field("idle", TICK_W'(want.idle), TICK_W'(out_tuser));
      check_field("finished", TICK_W'(want.finished), TICK_W'(got.finished));
      check_field("turnaround", want.turnaround, got.turnaround);
      check_field("waiting", want.waiting, got.waiting);
      check_field("all_done", TICK_W'(want.all_done), TICK_W'(got.all_done));
    end
  endtask

  always @(posedge clk) begin
    if (out_tvalid && out_tready) check_result();
    if (calm) begin
      out_tready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 14);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    sched_res_t typed_res;
    int         n;
    int         ticks;
    int         pc;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Empty table, then extreme loads; slot 15 never arrives in time
    add_row(ROW_ITEM, OP_TICK, 0, 0, 0, 0, 0, 1'b1, 1'b1);
    add_row(ROW_ITEM, OP_LOAD, 0, 0, 0, 0, 0, 1'b1, 1'b1);
    add_row(ROW_ITEM, OP_LOAD, 15, 255, 65535, 255, 0, 1'b1, 1'b0);
    add_row(ROW_ITEM, OP_TICK, 7, 3, 1, 2, 0, 1'b1, 1'b0);
    // Priority tie between two slots
    add_row(ROW_CFG, OP_LOAD, 0, 0, 0, 0, 2, 1'b0, 1'b0);
    add_row(ROW_ITEM, OP_LOAD, 1, 2, 0, 5, 0, 1'b0, 1'b0);
    add_row(ROW_ITEM, OP_LOAD, 0, 1, 0, 5, 0, 1'b0, 1'b0);
    repeat (4) add_row(ROW_ITEM, OP_TICK, 0, 0, 0, 0, 0, 1'b0, 1'b0);
    // Slot count of zero, late arrival gives idle ticks first
    add_row(ROW_CFG, OP_LOAD, 0, 0, 0, 0, 0, 1'b0, 1'b0);
    add_row(ROW_ITEM, OP_LOAD, 0, 2, 2, 255, 0, 1'b0, 1'b0);
    repeat (5) add_row(ROW_ITEM, OP_TICK, 0, 0, 0, 0, 0, 1'b0, 1'b0);
    // Slot count above the table size; urgent late task preempts
    add_row(ROW_CFG, OP_LOAD, 0, 0, 0, 0, 31, 1'b0, 1'b0);
    add_row(ROW_ITEM, OP_LOAD, 2, 3, 0, 9, 0, 1'b0, 1'b0);
    add_row(ROW_ITEM, OP_LOAD, 3, 1, 1, 0, 0, 1'b0, 1'b0);
    repeat (4) add_row(ROW_ITEM, OP_TICK, 0, 0, 0, 0, 0, 1'b0, 1'b0);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        set_slot_count(PC_W'(dir_rows[i].cfg_val));
      end else begin
        typed_res = '0;
        typed_res.idle = 1'b1;
        typed_res.all_done = dir_rows[i].exp_done;
        send_word(dir_rows[i].op, SLOT_W'(dir_rows[i].slot), BURST_W'(dir_rows[i].burst),
                  ARR_W'(dir_rows[i].arrival), PRIO_W'(dir_rows[i].prio),
                  dir_rows[i].typed, typed_res);
      end
    end

    n = words_sent + RANDOM_WORDS;
    while (words_sent < n) begin
      if (words_sent > n - CALM_WORDS) calm = 1'b1;
      case ($urandom_range(0, 9))
        0: pc = 0;
        1: pc = 1;
        2: pc = MAX_SLOTS;
        3: pc = $urandom_range(MAX_SLOTS + 1, 31);
        default: pc = $urandom_range(2, MAX_SLOTS);
      endcase
      // keep the slot count once the closing stretch runs without gaps
      if (!calm) set_slot_count(PC_W'(pc));
      if ($urandom_range(0, 9) < 8) begin
        // Fill every slot in use, then run the table down
        for (int s = 0; s < active_slots(); s++) send_load(s);
        if (active_slots() < MAX_SLOTS && $urandom_range(0, 3) == 0)
          send_load($urandom_range(active_slots(), MAX_SLOTS - 1));
        ticks = 0;
        while (!table_done() && ticks < TICK_CAP) begin
          if ($urandom_range(0, 29) == 0) send_load($urandom_range(0, MAX_SLOTS - 1));
          send_tick();
          ticks++;
        end
        repeat ($urandom_range(0, 3)) send_tick();
      end else begin
        repeat ($urandom_range(10, 30)) begin
          if ($urandom_range(0, 1) == 0) send_tick();
          else send_load($urandom_range(0, MAX_SLOTS - 1));
        end
      end
    end

    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
    if (error_count == 0 && expected_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
